// ===== rtl/n2a_pkg.sv =====
// Shared types, constants and helpers for the number to ASCII formatter.
`default_nettype none

package n2a_pkg;

    // Format selector carried on the input tuser
    typedef enum logic [2:0] {
        OP_HEX_AUTO = 3'd0,
        OP_RAW      = 3'd1,
        OP_HEX4     = 3'd2,
        OP_HEX8     = 3'd3,
        OP_DEC      = 3'd4
    } t_op;

    localparam int MAX_CHARS  = 8;
    localparam int CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int DEC_DIGITS = 5;
    localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);

    // n / 10 == (n * 52429) >> 19 for every 16-bit n
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_ALPHA = 8'd55;

    // One formatted value: chr[0] leaves first, cnt characters are valid
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [MAX_CHARS-1:0][7:0] chr;
    } t_ent;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return ASCII_ZERO + {4'd0, n};
        end
        return ASCII_ALPHA + {4'd0, n};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/n2a_front.sv =====
// Front end: accepts values, builds hex/raw strings directly and decimal ones digit by digit.
`default_nettype none

module n2a_front
    import n2a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic [7:0]  i_s_tuser,   // [2:0] op, [7:3] zero
    input  wire logic        i_full,
    output logic             o_push,
    output t_ent             o_ent
);

    logic                        r_busy, n_busy;
    logic [DIG_CNT_W-1:0]        r_cnt, n_cnt;
    logic [15:0]                 r_t, n_t;
    logic [DEC_DIGITS-1:0][3:0]  r_dig, n_dig;

    logic        accept;
    logic [15:0] v16;
    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] rem16;
    logic        push_hex, push_dec;
    t_ent        hex_ent, dec_ent;
    logic [2:0]  first;

    assign v16        = i_s_tdata[15:0];
    assign o_s_tready = !r_busy && !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // One decimal digit per cycle: reciprocal multiply, then remainder by shift-add
    assign prod  = 32'(r_t) * 32'(DIV10_MUL);
    assign quot  = prod[31:DIV10_SHIFT];
    assign rem16 = r_t - {quot, 3'b000} - {2'b00, quot, 1'b0};

    always_comb begin
        hex_ent  = '0;
        push_hex = 1'b0;
        case (t_op'(i_s_tuser[2:0]))
            OP_HEX_AUTO: begin
                push_hex = 1'b1;
                if (v16 <= 16'h00FF) begin
                    hex_ent.cnt = CNT_W'(2);
                    for (int i = 0; i < 2; i++) begin
                        hex_ent.chr[i] = hex_char(v16[7-4*i -: 4]);
                    end
                end else begin
                    hex_ent.cnt = CNT_W'(4);
                    for (int i = 0; i < 4; i++) begin
                        hex_ent.chr[i] = hex_char(v16[15-4*i -: 4]);
                    end
                end
            end
            OP_RAW: begin
                push_hex       = 1'b1;
                hex_ent.cnt    = CNT_W'(2);
                hex_ent.chr[0] = v16[15:8];
                hex_ent.chr[1] = v16[7:0];
            end
            OP_HEX4: begin
                push_hex    = 1'b1;
                hex_ent.cnt = CNT_W'(4);
                for (int i = 0; i < 4; i++) begin
                    hex_ent.chr[i] = hex_char(v16[15-4*i -: 4]);
                end
            end
            OP_HEX8: begin
                push_hex    = 1'b1;
                hex_ent.cnt = CNT_W'(8);
                for (int i = 0; i < MAX_CHARS; i++) begin
                    hex_ent.chr[i] = hex_char(i_s_tdata[31-4*i -: 4]);
                end
            end
            default: begin
                push_hex = 1'b0;
            end
        endcase
        push_hex = push_hex && accept;
    end

    // Strip leading zeros, keep at least the units digit
    always_comb begin
        if (r_dig[0] != 4'd0) begin
            first = 3'd0;
        end else if (r_dig[1] != 4'd0) begin
            first = 3'd1;
        end else if (r_dig[2] != 4'd0) begin
            first = 3'd2;
        end else if (r_dig[3] != 4'd0) begin
            first = 3'd3;
        end else begin
            first = 3'd4;
        end
        dec_ent     = '0;
        dec_ent.cnt = CNT_W'(DEC_DIGITS) - CNT_W'(first);
        for (int i = 0; i < DEC_DIGITS; i++) begin
            for (int k = 0; k < DEC_DIGITS; k++) begin
                if (3'(k) == 3'(i) + first) begin
                    dec_ent.chr[i] = ASCII_ZERO + {4'd0, r_dig[k]};
                end
            end
        end
    end

    assign push_dec = r_busy && (r_cnt == DIG_CNT_W'(DEC_DIGITS)) && !i_full;
    assign o_push   = push_hex || push_dec;
    assign o_ent    = r_busy ? dec_ent : hex_ent;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_t    = r_t;
        n_dig  = r_dig;
        if (r_busy) begin
            if (r_cnt != DIG_CNT_W'(DEC_DIGITS)) begin
                n_t   = 16'(quot);
                n_dig = {r_dig[DEC_DIGITS-2:0], rem16[3:0]};
                n_cnt = r_cnt + 1'b1;
            end else if (push_dec) begin
                n_busy = 1'b0;
            end
        end else if (accept && t_op'(i_s_tuser[2:0]) == OP_DEC) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_t    = v16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_t   <= n_t;
        r_dig <= n_dig;
    end

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != DIG_CNT_W'(DEC_DIGITS) |=> r_busy && r_cnt == $past(r_cnt) + 1'b1)
        else $error("decimal conversion did not advance");

    a_one_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push_hex && r_busy))
        else $error("input taken during decimal conversion");

endmodule

`default_nettype wire

// ===== rtl/n2a_queue.sv =====
// Small FIFO of formatted strings between front and back ends.
`default_nettype none

module n2a_queue
    import n2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_ent      i_ent,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_ent      o_ent
);

    t_ent           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_count;

    assign o_full  = r_count == QCW'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_ent   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/n2a_back.sv =====
// Back end: shifts out one character per beat from the current string.
`default_nettype none

module n2a_back
    import n2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  t_ent            i_ent,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_char
    output logic            o_m_tlast    // last_char
);

    logic [MAX_CHARS-1:0][7:0] r_chr;
    logic [CNT_W-1:0]          r_left;
    logic                      load_out;
    logic                      buf_done;

    assign load_out = (!o_m_tvalid || i_m_tready) && r_left != '0;
    // Refill as the last character moves into the output register
    assign buf_done = r_left == '0 || (load_out && r_left == CNT_W'(1));
    assign o_pop    = i_valid && buf_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_left <= i_ent.cnt;
            end else if (load_out) begin
                r_left <= r_left - 1'b1;
            end
            if (load_out) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_chr <= i_ent.chr;
        end else if (load_out) begin
            r_chr <= {8'd0, r_chr[MAX_CHARS-1:1]};
        end
        if (load_out) begin
            o_m_tdata <= r_chr[0];
            o_m_tlast <= r_left == CNT_W'(1);
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(MAX_CHARS))
        else $error("character count out of range");

endmodule

`default_nettype wire

// ===== rtl/number_to_ascii_formatter_core.sv =====
// Top level of the number to ASCII formatter.
//
// Input stream: tdata carries a 32-bit value, tuser[2:0] the format
// (hex auto width, raw two bytes, hex 4 digits, hex 8 digits, decimal).
// Output stream: one character per beat in tdata, tlast on the final
// character of each value. Undefined formats produce no beats.
// Hex and raw values are built in the cycle they are accepted; decimal
// values are built in the front end one digit per cycle through a
// reciprocal multiplier and then handed over once the queue has room,
// during which tready is low.
// A four-entry string queue parts the front end from the character
// shifter, so input is taken while earlier strings are still going out.
// While the receiver is ready and strings are waiting, the output runs
// at one character per cycle, back to back across values, so for hex
// and raw values (2 to 8 characters) the output port is the limit; a
// decimal value holds the input for longer than its characters take to
// go out, so decimal runs are limited by the front end.
// A stalled receiver holds the current beat; the queue then fills and
// tready drops. Synchronous reset empties the queue and drops all beats.
`default_nettype none

module number_to_ascii_formatter_core
    import n2a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic [7:0]  i_s_tuser,   // [2:0] op, [7:3] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_char
    output logic             o_m_tlast    // last_char
);

    logic push, full, pop, q_valid;
    t_ent push_ent, q_ent;

    n2a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_ent      (push_ent)
    );

    n2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    n2a_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_ent      (q_ent),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for number_to_ascii_formatter_core: directed and random stimulus checked by a character scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import n2a_pkg::*;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam int         LONG_HOLD       = 300;
    localparam logic [15:0] EDGE_VALUES [10] = '{
        16'd0, 16'd9, 16'd10, 16'd99, 16'd100,
        16'd255, 16'd256, 16'd9999, 16'd10000, 16'd65535
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    class char_scoreboard;
        t_char_beat pending_chars[$];
        int         errors;
        int         chars_checked;
        int         op_seen[8];

        task flag_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function logic [7:0] hex_glyph(input logic [3:0] n);
            return (n < 4'd10) ? 8'd48 + {4'd0, n} : 8'd55 + {4'd0, n};
        endfunction

        function void push_hex(input logic [31:0] v, input int digits);
            t_char_beat b;
            for (int i = 0; i < digits; i++) begin
                b.ch   = hex_glyph(4'(v >> (4 * (digits - 1 - i))));
                b.last = (i == digits - 1);
                pending_chars.push_back(b);
            end
        endfunction

        function void push_decimal(input logic [15:0] v);
            logic [3:0]  dig [5];
            int unsigned rest;
            int          lead;
            t_char_beat  b;
            rest = v;
            for (int i = 4; i >= 0; i--) begin
                dig[i] = 4'(rest % 10);
                rest   = rest / 10;
            end
            lead = 0;
            while (lead < 4 && dig[lead] == 4'd0) lead++;
            for (int i = lead; i < 5; i++) begin
                b.ch   = 8'd48 + {4'd0, dig[i]};
                b.last = (i == 4);
                pending_chars.push_back(b);
            end
        endfunction

        // Expand one accepted value into the characters it must produce
        function void note_input(input logic [2:0] op, input logic [31:0] value);
            t_char_beat b;
            op_seen[op]++;
            case (op)
                OP_HEX_AUTO: push_hex({16'd0, value[15:0]}, (value[15:0] <= 16'd255) ? 2 : 4);
                OP_RAW: begin
                    b.ch   = value[15:8];
                    b.last = 1'b0;
                    pending_chars.push_back(b);
                    b.ch   = value[7:0];
                    b.last = 1'b1;
                    pending_chars.push_back(b);
                end
                OP_HEX4: push_hex({16'd0, value[15:0]}, 4);
                OP_HEX8: push_hex(value, 8);
                OP_DEC:  push_decimal(value[15:0]);
                default: ;
            endcase
        endfunction

        task check_beat(input logic [7:0] ch, input logic last);
            t_char_beat want;
            if (pending_chars.size() == 0) begin
                flag_mismatch($sformatf("char 0x%02h last %0b with nothing outstanding", ch, last));
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch)
                flag_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
            if (last !== want.last)
                flag_mismatch($sformatf("last %0b on char 0x%02h, want %0b", last, ch, want.last));
        endtask

        task close_out();
            if (pending_chars.size() != 0)
                flag_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic [7:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    logic calm        = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_active = 1'b0;

    char_scoreboard chars_sb = new;

    number_to_ascii_formatter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [31:0] value
        .i_s_tuser  (i_s_tuser),    // [2:0] op, [7:3] zero
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [7:0] out_char
        .o_m_tlast  (o_m_tlast)     // last_char
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            chars_sb.check_beat(o_m_tdata, o_m_tlast);
    end

    // Receiver: random stall bursts, one long hold on request
    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready  <= 1'b0;
                hold_active = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                i_m_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_value(input logic [2:0] op, input logic [31:0] value);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= {5'd0, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        chars_sb.note_input(op, value);
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int unsigned k;
        v = $urandom;
        k = $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0: ;
            1: v[15:8] = 8'd0;
            2: v[15:0] = v[15:0] & 16'((32'd1 << k) - 1);
            default: v[15:0] = EDGE_VALUES[$urandom_range(0, 9)];
        endcase
        return v;
    endfunction

    // Mostly defined formats; unused codes mixed in and not counted
    task automatic send_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 19) == 0) begin
                send_value(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), $urandom);
            end else begin
                send_value(3'($urandom_range(OP_HEX_AUTO, OP_DEC)), pick_value());
                sent++;
            end
        end
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_value(OP_HEX_AUTO, 32'h0000_0000);
        send_value(OP_HEX_AUTO, 32'h0000_00FF);
        send_value(OP_HEX_AUTO, 32'h0000_0100);
        send_value(OP_HEX_AUTO, 32'hABCD_0012);
        send_value(OP_HEX_AUTO, 32'h0000_FFFF);
        send_value(OP_RAW,      32'h0000_1234);
        send_value(OP_RAW,      32'hFFFF_00FF);
        send_value(OP_HEX4,     32'h0000_0000);
        send_value(OP_HEX4,     32'hFEDC_BA98);
        send_value(OP_HEX8,     32'h0000_0000);
        send_value(OP_HEX8,     32'hFFFF_FFFF);
        send_value(OP_HEX8,     32'h0123_4567);
        send_value(OP_HEX8,     32'h89AB_CDEF);
        send_value(OP_DEC,      32'h0000_0000);
        send_value(OP_DEC,      32'd9);
        send_value(OP_DEC,      32'd10);
        send_value(OP_DEC,      32'd99);
        send_value(OP_DEC,      32'd100);
        send_value(OP_DEC,      32'd9999);
        send_value(OP_DEC,      32'd10000);
        send_value(OP_DEC,      32'd65535);
        send_value(OP_DEC,      32'hFFFF_2710);
        send_value(OP_FIRST_UNUSED,        32'hFFFF_FFFF);
        send_value(OP_FIRST_UNUSED + 3'd1, 32'h1234_5678);
        send_value(OP_LAST_UNUSED,         32'h0000_0000);

        send_random(120);

        // Hold the output and keep offering beats so the string queue fills
        hold_req = 1'b1;
        wait (hold_active);
        calm = 1'b1;
        send_random(20);
        calm = 1'b0;

        send_random(60);
        calm = 1'b1;
        send_random(100);
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (chars_sb.pending_chars.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        chars_sb.close_out();

        $display("covered %0d hex-auto, %0d raw, %0d hex4, %0d hex8, %0d decimal values",
                 chars_sb.op_seen[OP_HEX_AUTO], chars_sb.op_seen[OP_RAW],
                 chars_sb.op_seen[OP_HEX4], chars_sb.op_seen[OP_HEX8],
                 chars_sb.op_seen[OP_DEC]);
        $display("plus %0d unused format codes; %0d characters compared, one long output hold",
                 chars_sb.op_seen[5] + chars_sb.op_seen[6] + chars_sb.op_seen[7],
                 chars_sb.chars_checked);
        if (chars_sb.errors == 0) begin
            $display("PASS number_to_ascii_formatter_core");
        end else begin
            $display("FAIL number_to_ascii_formatter_core");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL number_to_ascii_formatter_core");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/n2a_pkg.sv
rtl/n2a_front.sv
rtl/n2a_queue.sv
rtl/n2a_back.sv
rtl/number_to_ascii_formatter_core.sv
verif/tb_top.sv
